// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sampler RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CPL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define CPL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/cpl_pkg.sv -----
// ---------------------------------------------------------------------------
// cpl_pkg
// Types and fixed widths shared by the closed polyline sampler modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cpl_pkg;

   localparam int COORD_W = 32;   // Q16.16 coordinate
   localparam int DIST_W  = 48;   // Q32.16 distance
   localparam int DIR_W   = 16;   // Q1.15 direction
   localparam int DIFF_W  = 33;   // signed coordinate difference
   localparam int MAG_W   = 33;   // magnitude of a difference
   localparam int OPND_W  = 34;   // multiplier operand
   localparam int PROD_W  = 68;   // multiplier product and dividend
   localparam int RAD_W   = 66;   // sum of three squares
   localparam int ROOT_W  = 34;   // segment length
   localparam int DEN_W   = 48;   // divisor and remainder
   localparam int CNT_W   = 7;    // point_count register

   localparam logic signed [DIR_W-1:0] DIR_ONE = 16'sd32767;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } point_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   function automatic logic signed [COORD_W-1:0] point_axis(point_type p, logic [1:0] a);
      logic signed [COORD_W-1:0] v;
      unique case (a)
         2'd0:    v = p.x;
         2'd1:    v = p.y;
         default: v = p.z;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cpl_point_mem.sv -----
// ---------------------------------------------------------------------------
// cpl_point_mem
// Point table: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpl_point_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire cpl_pkg::point_type wr_data,
   input  wire logic               rd_en,
   input  wire logic [AW-1:0]      rd_addr,
   output cpl_pkg::point_type      rd_data
);
   import cpl_pkg::*;

   point_type mem_ff [DEPTH];
   point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/cpl_sqrt.sv -----
// ---------------------------------------------------------------------------
// cpl_sqrt
// Floor square root, one result bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpl_sqrt (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [cpl_pkg::RAD_W-1:0]   radicand,
   output cpl_pkg::unit_status_type         status,
   output logic      [cpl_pkg::ROOT_W-1:0]  root
);
   import cpl_pkg::*;

   localparam int PAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 2;

   logic [PAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [REM_W+1:0]  rem_sh, trial;

   always_comb begin
      rem_sh  = {rem_ff, rad_ff[PAD_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = PAD_W'(radicand);
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 6'(ROOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[PAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = REM_W'(rem_sh - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(rem_sh);
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign root        = root_ff;

endmodule

`default_nettype wire

// ----- rtl/core/cpl_div.sv -----
// ---------------------------------------------------------------------------
// cpl_div
// Unsigned restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpl_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [cpl_pkg::PROD_W-1:0]  dividend,
   input  wire logic [cpl_pkg::DEN_W-1:0]   divisor,
   output cpl_pkg::unit_status_type         status,
   output logic      [cpl_pkg::PROD_W-1:0]  quotient,
   output logic      [cpl_pkg::DEN_W-1:0]   remainder
);
   import cpl_pkg::*;

   logic [PROD_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [6:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W:0]    rem_sh;

   always_comb begin
      rem_sh  = {rem_ff, num_ff[PROD_W-1]};
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
         cnt_in  = 7'(PROD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift the quotient bit in behind the dividend
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(rem_sh - {1'b0, den_ff});
            num_in = {num_ff[PROD_W-2:0], 1'b1};
         end else begin
            rem_in = DEN_W'(rem_sh);
            num_in = {num_ff[PROD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = num_ff;
   assign remainder   = rem_ff;

endmodule

`default_nettype wire

// ----- rtl/core/closed_polyline_distance_sampler.sv -----
// ---------------------------------------------------------------------------
// closed_polyline_distance_sampler
// Samples a closed loop of 3D points at a signed travel distance.
// ---------------------------------------------------------------------------
//
// Channel  Dir  Handshake             Payload
// req      in   req_tvalid/tready     tdata: index, x, y, z, distance; tuser: op
// rsp      out  rsp_tvalid/tready     tdata: pos x/y/z, dir x/y/z; tuser: valid
// csr      in   csr_wr_en             csr_wr_data: point_count
//
// Write items are accepted whenever no sample is in progress. A sample walks
// the loop at most twice, one segment at a time, and most of the time per
// segment goes to the bit-serial square root. Between the passes comes one
// wrap divide, and after the second pass six divides for position and
// direction, all in the one divider unit. No clearing pass after reset.
// A stalled result waits in the output register while further write items
// are taken.
//
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module closed_polyline_distance_sampler #(
   parameter int MAX_POINTS = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // req_tdata, low bit up: point_index[6], coord_x[32], coord_y[32],
   // coord_z[32], travel_distance[48], zero pad[2]
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [151:0] req_tdata,
   input  wire logic         req_tuser,    // operation
   // rsp_tdata, low bit up: pos_x[32], pos_y[32], pos_z[32],
   // dir_x[16], dir_y[16], dir_z[16]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [143:0]      rsp_tdata,
   output logic              rsp_tuser,    // sample_valid
   input  wire logic         csr_wr_en,
   input  wire logic [6:0]   csr_wr_data   // point_count
);
   import cpl_pkg::*;

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_READ0, S_LOAD0, S_READB, S_LOADB,
      S_SQX, S_SQY, S_SQZ, S_ROOT_GO, S_ROOT_WAIT,
      S_MOD_GO, S_MOD_WAIT, S_POS_MUL, S_POS_GO, S_POS_WAIT,
      S_DIR_GO, S_DIR_WAIT, S_EMIT
   } state_type;

   // input unpacking
   logic                      req_fire;
   logic [5:0]                in_index;
   point_type                 in_point;
   logic signed [DIST_W-1:0]  in_dist;

   assign req_fire  = req_tvalid && req_tready;
   assign in_index  = req_tdata[5:0];
   assign in_point  = {req_tdata[101:70], req_tdata[69:38], req_tdata[37:6]};
   assign in_dist   = req_tdata[149:102];

   // control and datapath registers
   state_type                 state_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [CW-1:0]             n_ff;
   logic [AW-1:0]             i_ff, j_ff;
   logic                      pass2_ff;
   logic signed [DIST_W-1:0]  dist_ff;
   point_type                 p0_ff, pa_ff, pb_ff;
   logic signed [DIFF_W-1:0]  d_ff [3];
   logic [1:0]                axis_ff;
   logic [PROD_W-1:0]         acc_ff;
   logic [DEN_W-1:0]          total_ff, accum_ff, wdist_ff;
   logic [OPND_W-1:0]         off_ff;
   logic signed [COORD_W-1:0] res_pos_ff [3];
   logic signed [DIR_W-1:0]   res_dir_ff [3];
   logic                      res_valid_ff;
   logic                      rsp_valid_ff;
   logic [143:0]              rsp_data_ff;
   logic                      rsp_user_ff;

   // memory port
   logic                      mem_wr_en, mem_rd_en;
   logic [AW-1:0]             mem_rd_addr;
   point_type                 mem_rd_data;

   assign mem_wr_en   = req_fire && (op_type'(req_tuser) == OP_WRITE)
                        && ({26'd0, in_index} < 32'(MAX_POINTS));
   assign mem_rd_en   = (state_ff == S_READ0) || (state_ff == S_READB);
   assign mem_rd_addr = (state_ff == S_READ0) ? '0 : j_ff;

   cpl_point_mem #(
      .DEPTH(MAX_POINTS),
      .AW   (AW)
   ) u_mem (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(AW'(in_index)),
      .wr_data(in_point),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   // shared multiplier: squares of the differences, then |d| * offset
   logic [1:0]                mul_axis;
   logic signed [DIFF_W-1:0]  sel_d;
   logic                      sel_neg;
   logic [MAG_W-1:0]          sel_mag;
   logic [OPND_W-1:0]         mul_b;
   logic [PROD_W-1:0]         mul_p;

   always_comb begin
      priority case (state_ff)
         S_SQX:   mul_axis = 2'd0;
         S_SQY:   mul_axis = 2'd1;
         S_SQZ:   mul_axis = 2'd2;
         default: mul_axis = axis_ff;
      endcase
      sel_d   = d_ff[mul_axis];
      sel_neg = sel_d[DIFF_W-1];
      sel_mag = sel_neg ? MAG_W'(-sel_d) : MAG_W'(sel_d);
      mul_b   = (state_ff == S_POS_MUL) ? off_ff : OPND_W'(sel_mag);
      mul_p   = PROD_W'(OPND_W'(sel_mag)) * PROD_W'(mul_b);
   end

   // square root and divider units
   unit_status_type           sq_stat, dv_stat;
   logic [ROOT_W-1:0]         sq_root;
   logic                      sq_go, dv_go;
   logic [PROD_W-1:0]         dv_num, dv_quo;
   logic [DEN_W-1:0]          dv_den, dv_rem;
   logic [DIST_W-1:0]         dist_mag;

   function automatic logic [DEN_W-1:0] len_ext(logic [ROOT_W-1:0] v);
      return DEN_W'(v);
   endfunction

   assign dist_mag = dist_ff[DIST_W-1] ? DIST_W'(-dist_ff) : DIST_W'(dist_ff);
   assign sq_go    = (state_ff == S_ROOT_GO);
   assign dv_go    = (state_ff == S_MOD_GO) || (state_ff == S_POS_GO)
                     || (state_ff == S_DIR_GO);

   always_comb begin
      unique case (state_ff)
         S_MOD_GO: begin
            dv_num = PROD_W'(dist_mag);
            dv_den = total_ff;
         end
         S_POS_GO: begin
            dv_num = acc_ff;
            dv_den = DEN_W'(len_ext(sq_root));
         end
         default: begin
            dv_num = PROD_W'({sel_mag, 15'd0});
            dv_den = DEN_W'(len_ext(sq_root));
         end
      endcase
   end

   cpl_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_go),
      .radicand(acc_ff[RAD_W-1:0]),
      .status  (sq_stat),
      .root    (sq_root)
   );

   cpl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dv_go),
      .dividend (dv_num),
      .divisor  (dv_den),
      .status   (dv_stat),
      .quotient (dv_quo),
      .remainder(dv_rem)
   );

   // segment bookkeeping
   logic                      last_seg, next_last;
   logic [DEN_W:0]            reach;
   logic [DEN_W-1:0]          seg_len;
   logic signed [COORD_W-1:0] pos_new;
   logic [DIR_W-1:0]          dir_mag;

   always_comb begin
      seg_len   = len_ext(sq_root);
      last_seg  = ((CW'(i_ff) + CW'(1)) == n_ff);
      next_last = ((CW'(i_ff) + CW'(2)) == n_ff);
      reach     = {1'b0, accum_ff} + {1'b0, seg_len};
      pos_new   = point_axis(pa_ff, axis_ff)
                  + (sel_neg ? -$signed(dv_quo[COORD_W-1:0])
                             : $signed(dv_quo[COORD_W-1:0]));
      dir_mag   = (|dv_quo[PROD_W-1:15]) ? DIR_W'(DIR_ONE) : DIR_W'(dv_quo[14:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         // drop the output item once taken, unless a new one replaces it
         if (rsp_valid_ff && rsp_tready && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               // defaults for the invalid answers
               for (int k = 0; k < 3; k++) begin
                  res_pos_ff[k] <= '0;
                  res_dir_ff[k] <= (k == 0) ? DIR_ONE : '0;
               end
               res_valid_ff  <= 1'b0;
               if (req_fire && (op_type'(req_tuser) == OP_SAMPLE)) begin
                  dist_ff <= in_dist;
                  n_ff    <= ({25'd0, count_ff} > 32'(MAX_POINTS)) ?
                             CW'(MAX_POINTS) : CW'(count_ff);
                  if (count_ff == '0) begin
                     state_ff <= S_EMIT;
                  end else begin
                     state_ff <= S_READ0;
                  end
               end
            end
            S_READ0: begin
               state_ff <= S_LOAD0;
            end
            S_LOAD0: begin
               p0_ff         <= mem_rd_data;
               pa_ff         <= mem_rd_data;
               res_pos_ff[0] <= mem_rd_data.x;
               res_pos_ff[1] <= mem_rd_data.y;
               res_pos_ff[2] <= mem_rd_data.z;
               i_ff          <= '0;
               j_ff          <= AW'(1);
               pass2_ff      <= 1'b0;
               total_ff      <= '0;
               if (n_ff == CW'(1)) begin
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_READB;
               end
            end
            S_READB: begin
               state_ff <= S_LOADB;
            end
            S_LOADB: begin
               pb_ff   <= mem_rd_data;
               d_ff[0] <= DIFF_W'(mem_rd_data.x) - DIFF_W'(pa_ff.x);
               d_ff[1] <= DIFF_W'(mem_rd_data.y) - DIFF_W'(pa_ff.y);
               d_ff[2] <= DIFF_W'(mem_rd_data.z) - DIFF_W'(pa_ff.z);
               state_ff <= S_SQX;
            end
            S_SQX: begin
               acc_ff   <= mul_p;
               state_ff <= S_SQY;
            end
            S_SQY: begin
               acc_ff   <= acc_ff + mul_p;
               state_ff <= S_SQZ;
            end
            S_SQZ: begin
               acc_ff   <= acc_ff + mul_p;
               state_ff <= S_ROOT_GO;
            end
            S_ROOT_GO: begin
               state_ff <= S_ROOT_WAIT;
            end
            S_ROOT_WAIT: begin
               if (sq_stat.done) begin
                  if (pass2_ff && (seg_len != '0) && ({1'b0, wdist_ff} <= reach)) begin
                     // this segment covers the wrapped distance
                     off_ff   <= OPND_W'(wdist_ff - accum_ff);
                     axis_ff  <= 2'd0;
                     state_ff <= S_POS_MUL;
                  end else begin
                     if (pass2_ff) begin
                        accum_ff <= accum_ff + seg_len;
                     end else begin
                        total_ff <= total_ff + seg_len;
                     end
                     if (last_seg) begin
                        if (pass2_ff) begin
                           res_valid_ff <= 1'b1;
                           state_ff     <= S_EMIT;
                        end else if ((total_ff + seg_len) == '0) begin
                           state_ff <= S_EMIT;
                        end else begin
                           state_ff <= S_MOD_GO;
                        end
                     end else begin
                        pa_ff    <= pb_ff;
                        i_ff     <= i_ff + AW'(1);
                        j_ff     <= next_last ? '0 : (i_ff + AW'(2));
                        state_ff <= S_READB;
                     end
                  end
               end
            end
            S_MOD_GO: begin
               state_ff <= S_MOD_WAIT;
            end
            S_MOD_WAIT: begin
               if (dv_stat.done) begin
                  // remainder takes the sign of the distance, then wraps up
                  wdist_ff <= (dist_ff[DIST_W-1] && (dv_rem != '0)) ?
                              (total_ff - dv_rem) : dv_rem;
                  accum_ff <= '0;
                  pass2_ff <= 1'b1;
                  pa_ff    <= p0_ff;
                  i_ff     <= '0;
                  j_ff     <= AW'(1);
                  state_ff <= S_READB;
               end
            end
            S_POS_MUL: begin
               acc_ff   <= mul_p;
               state_ff <= S_POS_GO;
            end
            S_POS_GO: begin
               state_ff <= S_POS_WAIT;
            end
            S_POS_WAIT: begin
               if (dv_stat.done) begin
                  res_pos_ff[axis_ff] <= pos_new;
                  state_ff            <= S_DIR_GO;
               end
            end
            S_DIR_GO: begin
               state_ff <= S_DIR_WAIT;
            end
            S_DIR_WAIT: begin
               if (dv_stat.done) begin
                  res_dir_ff[axis_ff] <= sel_neg ? -$signed(dir_mag) : $signed(dir_mag);
                  if (axis_ff == 2'd2) begin
                     res_valid_ff <= 1'b1;
                     state_ff     <= S_EMIT;
                  end else begin
                     axis_ff  <= axis_ff + 2'd1;
                     state_ff <= S_POS_MUL;
                  end
               end
            end
            S_EMIT: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {res_dir_ff[2], res_dir_ff[1], res_dir_ff[0],
                                   res_pos_ff[2], res_pos_ff[1], res_pos_ff[0]};
                  rsp_user_ff  <= res_valid_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   logic sample_fire, rsp_invalid, rsp_dir_default;

   assign sample_fire     = req_fire && (op_type'(req_tuser) == OP_SAMPLE);
   assign rsp_invalid     = rsp_tvalid && !rsp_tuser;
   assign rsp_dir_default = (rsp_tdata[111:96] == DIR_ONE) && (rsp_tdata[143:112] == '0);

   `CPL_ASSERT_IMP(a_sqrt_idle_start, clock, reset, sq_go, !sq_stat.busy, "sqrt start busy")
   `CPL_ASSERT_IMP(a_div_idle_start, clock, reset, dv_go, !dv_stat.busy, "div start busy")
   `CPL_ASSERT_IMP(a_invalid_dir, clock, reset, rsp_invalid, rsp_dir_default, "bad invalid dir")
   `CPL_ASSERT_NXT(a_sample_blocks, clock, reset, sample_fire, !req_tready, "sample not blocking")

endmodule

`default_nettype wire
